// ----- hw/rtl/frtn_pkg.sv -----
package frtn_pkg;

    // Field widths
    localparam int NUM_W    = 32;
    localparam int DEN_W    = 32;
    localparam int CFG_W    = 8;
    localparam int FL_W     = 16;
    localparam int TS_W     = 41;
    localparam int MULT_W   = 9;
    localparam int REG_IDX_W = 8;

    // Shared arithmetic units
    localparam int DIV_DVD_W = 40;   // holds num * max_denominator
    localparam int DIV_DVS_W = 32;
    localparam int MUL_MC_W  = 32;
    localparam int MUL_MP_W  = 9;

    // Configuration registers
    localparam logic [REG_IDX_W-1:0] REG_MAX_DEN = 8'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET  = 8'd1;
    localparam logic [CFG_W-1:0]     MAX_DEN_RST = 8'd20;
    localparam logic [CFG_W-1:0]     TARGET_RST  = 8'd19;

    typedef struct packed {
        logic [NUM_W-1:0] rate_numerator;
        logic [DEN_W-1:0] rate_denominator;
    } t_rate_in;

    typedef struct packed {
        logic            bad_rate;
        logic [FL_W-1:0] frame_length;
        logic [TS_W-1:0] time_scale;
    } t_norm_out;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_OUT
    } t_state;

    // Divider jobs
    typedef enum logic [2:0] {
        OP_GCD,
        OP_RDEN,
        OP_SCALE,
        OP_RNUM,
        OP_MULT
    } t_op;

    // Multiplier jobs
    typedef enum logic [1:0] {
        MOP_PROD,
        MOP_TS,
        MOP_FL
    } t_mop;

endpackage

// ----- hw/rtl/frtn_chan_if.sv -----
interface frtn_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/frtn_divider.sv -----
module frtn_divider
    import frtn_pkg::*;
#(
    parameter int DVD_W = DIV_DVD_W,
    parameter int DVS_W = DIV_DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   partial;
    logic [DVS_W:0]   trial;

    // One quotient bit per cycle: dividend shifts out of r_quo into the remainder
    assign partial = {r_rem, r_quo[DVD_W-1]};
    assign trial   = partial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!trial[DVS_W]) begin
                n_rem = trial[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = partial[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- hw/rtl/frtn_multiplier.sv -----
module frtn_multiplier
    import frtn_pkg::*;
#(
    parameter int MC_W = MUL_MC_W,
    parameter int MP_W = MUL_MP_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MC_W-1:0]      i_mcand,
    input  logic [MP_W-1:0]      i_mplier,
    output logic                 o_done,
    output logic [MC_W+MP_W-1:0] o_product
);

    localparam int P_W   = MC_W + MP_W;
    localparam int CNT_W = $clog2(MP_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [P_W-1:0]   r_acc, n_acc;
    logic [P_W-1:0]   r_mc, n_mc;
    logic [MP_W-1:0]  r_mp, n_mp;

    // Shift-add, one multiplier bit per cycle, LSB first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(MP_W);
            n_acc  = '0;
            n_mc   = P_W'(i_mcand);
            n_mp   = i_mplier;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                n_acc = r_acc + r_mc;
            end
            n_mc  = {r_mc[P_W-2:0], 1'b0};
            n_mp  = {1'b0, r_mp[MP_W-1:1]};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ----- hw/rtl/frame_rate_timescale_normalizer.sv -----
// Frame-rate timescale normalizer.
// i_rate (sink): one transaction carries a frame-rate fraction. o_norm (source):
// one transaction per input carries bad_rate, frame_length and time_scale.
// i_cfg (sink): register writes, index 0 = max_denominator, 1 = target_multiplier;
// always ready, write only while no rate is in flight.
// The block handles one rate at a time; i_rate.ready is high only when idle.
// Every remainder/quotient runs on one shared restoring divider that yields one
// quotient bit per cycle; each Euclid step is one more division. Products go
// through a shift-add multiplier. A zero denominator goes straight to the output
// register. E1/E2 are the Euclid remainder steps of the first and second gcd,
// the second gcd running only when rescaling; E1 is at most 46 for 32-bit
// operands and E2 at most 12. The next rate can be taken in the cycle after
// the result is taken.
// The result stays in its output register until o_norm.ready is seen; a stalled
// receiver only holds the block, nothing is lost.
// Reset (synchronous, active low) returns to idle and loads the registers with
// max_denominator = 20 and target_multiplier = 19.
module frame_rate_timescale_normalizer
    import frtn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    frtn_chan_if.sink   i_rate,
    frtn_chan_if.source o_norm,
    frtn_chan_if.sink   i_cfg
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_mop   r_mop, n_mop;

    logic [CFG_W-1:0]  r_max_den;
    logic [CFG_W-1:0]  r_target;
    logic [CFG_W-1:0]  mx;

    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W-1:0]  r_a, n_a;
    logic [DEN_W-1:0]  r_b, n_b;
    logic [DEN_W-1:0]  r_g, n_g;
    logic [DEN_W-1:0]  r_rden, n_rden;
    logic [NUM_W-1:0]  r_rnum, n_rnum;
    logic [MULT_W-1:0] r_mult, n_mult;
    logic              r_pass, n_pass;
    logic              r_bad, n_bad;
    logic [FL_W-1:0]   r_fl, n_fl;
    logic [TS_W-1:0]   r_ts, n_ts;

    logic                  div_start, div_done;
    logic [DIV_DVD_W-1:0]  div_dvd, div_quo;
    logic [DIV_DVS_W-1:0]  div_dvs, div_rem;
    logic                  mul_start, mul_done;
    logic [MUL_MC_W-1:0]   mul_mc;
    logic [MUL_MP_W-1:0]   mul_mp;
    logic [MUL_MC_W+MUL_MP_W-1:0] mul_prod;
    logic [NUM_W-1:0]      scaled_num;

    // A max_denominator of zero acts as one
    assign mx = (r_max_den == '0) ? CFG_W'(1) : r_max_den;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_den <= MAX_DEN_RST;
            r_target  <= TARGET_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_MAX_DEN: r_max_den <= i_cfg.data.reg_data;
                REG_TARGET:  r_target  <= i_cfg.data.reg_data;
                default: ;
            endcase
        end
    end

    frtn_divider #(
        .DVD_W(DIV_DVD_W),
        .DVS_W(DIV_DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_remainder(div_rem)
    );

    frtn_multiplier #(
        .MC_W(MUL_MC_W),
        .MP_W(MUL_MP_W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mc),
        .i_mplier (mul_mp),
        .o_done   (mul_done),
        .o_product(mul_prod)
    );

    // Operand selection, sampled by the units on start
    always_comb begin
        unique case (r_op)
            OP_GCD: begin
                div_dvd = DIV_DVD_W'(r_a);
                div_dvs = r_b;
            end
            OP_RDEN: begin
                div_dvd = DIV_DVD_W'(r_den);
                div_dvs = r_g;
            end
            OP_SCALE: begin
                div_dvd = mul_prod[DIV_DVD_W-1:0];
                div_dvs = r_den;
            end
            OP_RNUM: begin
                div_dvd = DIV_DVD_W'(r_num);
                div_dvs = r_g;
            end
            OP_MULT: begin
                div_dvd = DIV_DVD_W'(r_target);
                div_dvs = r_rden;
            end
            default: begin
                div_dvd = '0;
                div_dvs = r_b;
            end
        endcase
    end

    always_comb begin
        unique case (r_mop)
            MOP_PROD: begin
                mul_mc = r_num;
                mul_mp = MUL_MP_W'(mx);
            end
            MOP_TS: begin
                mul_mc = r_rnum;
                mul_mp = r_mult;
            end
            MOP_FL: begin
                mul_mc = r_rden;
                mul_mp = r_mult;
            end
            default: begin
                mul_mc = '0;
                mul_mp = '0;
            end
        endcase
    end

    // Rescaled numerator, rounded up when remainder exceeds max/2
    assign scaled_num = div_quo[NUM_W-1:0]
                      + NUM_W'(div_rem > DIV_DVS_W'(mx >> 1));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_mop     = r_mop;
        n_num     = r_num;
        n_den     = r_den;
        n_a       = r_a;
        n_b       = r_b;
        n_g       = r_g;
        n_rden    = r_rden;
        n_rnum    = r_rnum;
        n_mult    = r_mult;
        n_pass    = r_pass;
        n_bad     = r_bad;
        n_fl      = r_fl;
        n_ts      = r_ts;
        div_start = 1'b0;
        mul_start = 1'b0;
        i_rate.ready = 1'b0;
        o_norm.valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_rate.ready = 1'b1;
                if (i_rate.valid) begin
                    n_num  = i_rate.data.rate_numerator;
                    n_den  = i_rate.data.rate_denominator;
                    n_a    = i_rate.data.rate_numerator;
                    n_b    = i_rate.data.rate_denominator;
                    n_pass = 1'b0;
                    if (i_rate.data.rate_denominator == '0) begin
                        n_bad   = 1'b1;
                        n_fl    = '0;
                        n_ts    = '0;
                        n_state = S_OUT;
                    end else begin
                        n_bad   = 1'b0;
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_b == '0) begin
                    n_g  = r_a;
                    n_op = OP_RDEN;
                end else begin
                    n_op = OP_GCD;
                end
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    unique case (r_op)
                        OP_GCD: begin
                            n_a     = r_b;
                            n_b     = div_rem;
                            n_state = S_GCD;
                        end
                        OP_RDEN: begin
                            n_rden = div_quo[DEN_W-1:0];
                            if (!r_pass && div_quo[DEN_W-1:0] > DEN_W'(mx)) begin
                                n_mop   = MOP_PROD;
                                n_state = S_MUL_GO;
                            end else begin
                                n_op    = OP_RNUM;
                                n_state = S_DIV_GO;
                            end
                        end
                        OP_SCALE: begin
                            n_num   = scaled_num;
                            n_den   = DEN_W'(mx);
                            n_a     = scaled_num;
                            n_b     = DEN_W'(mx);
                            n_pass  = 1'b1;
                            n_state = S_GCD;
                        end
                        OP_RNUM: begin
                            n_rnum  = div_quo[NUM_W-1:0];
                            n_op    = OP_MULT;
                            n_state = S_DIV_GO;
                        end
                        OP_MULT: begin
                            n_mult  = MULT_W'(div_quo[CFG_W-1:0]) + MULT_W'(1);
                            n_mop   = MOP_TS;
                            n_state = S_MUL_GO;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL_GO: begin
                mul_start = 1'b1;
                n_state   = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    unique case (r_mop)
                        MOP_PROD: begin
                            n_op    = OP_SCALE;
                            n_state = S_DIV_GO;
                        end
                        MOP_TS: begin
                            n_ts    = mul_prod[TS_W-1:0];
                            n_mop   = MOP_FL;
                            n_state = S_MUL_GO;
                        end
                        MOP_FL: begin
                            n_fl    = mul_prod[FL_W-1:0];
                            n_state = S_OUT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_OUT: begin
                o_norm.valid = 1'b1;
                if (o_norm.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op   <= n_op;
        r_mop  <= n_mop;
        r_num  <= n_num;
        r_den  <= n_den;
        r_a    <= n_a;
        r_b    <= n_b;
        r_g    <= n_g;
        r_rden <= n_rden;
        r_rnum <= n_rnum;
        r_mult <= n_mult;
        r_pass <= n_pass;
        r_bad  <= n_bad;
        r_fl   <= n_fl;
        r_ts   <= n_ts;
    end

    assign o_norm.data.bad_rate     = r_bad;
    assign o_norm.data.frame_length = r_fl;
    assign o_norm.data.time_scale   = r_ts;

`ifndef ASSERT_OFF
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_MUL_WAIT)
        else $error("multiplier finished outside its wait state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rate.valid && i_rate.ready) |=> r_state != S_IDLE)
        else $error("input transaction accepted but block stayed idle");

    a_bad_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_norm.valid && o_norm.data.bad_rate) |->
            (o_norm.data.frame_length == '0 && o_norm.data.time_scale == '0))
        else $error("bad rate result carries nonzero fields");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import frtn_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    frtn_chan_if #(.T(t_rate_in))  rate_if ();
    frtn_chan_if #(.T(t_norm_out)) norm_if ();
    frtn_chan_if #(.T(t_cfg_wr))   cfg_if ();

    frame_rate_timescale_normalizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rate  (rate_if),
        .o_norm  (norm_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the two registers
    logic [CFG_W-1:0] max_den_q = MAX_DEN_RST;
    logic [CFG_W-1:0] target_q  = TARGET_RST;

    t_norm_out norm_exp_q[$];
    int        err_cnt     = 0;
    logic      idle_on     = 1'b1;
    int        rx_hold_len = 0;

    function automatic logic [63:0] euclid_gcd(input logic [63:0] a_in, input logic [63:0] b_in);
        logic [63:0] a, b, r;
        a = a_in;
        b = b_in;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_norm_out normalize_rate(input logic [31:0] num_in,
                                                 input logic [31:0] den_in);
        t_norm_out   res;
        logic [63:0] num, den, mx, g, rden, rnum, mult, prod, quo, rem, tgt, tmp;
        res = '0;
        num = 64'(num_in);
        den = 64'(den_in);
        mx  = (max_den_q == 0) ? 64'd1 : {56'd0, max_den_q};
        tgt = {56'd0, target_q};
        if (den == 0) begin
            res.bad_rate = 1'b1;
            return res;
        end
        g = euclid_gcd(num, den);
        if (den / g > mx) begin
            prod = num * mx;
            quo  = prod / den;
            rem  = prod % den;
            // rounds against half of max, not half of the divisor
            if (rem > (mx >> 1))
                quo = quo + 1;
            num = quo;
            den = mx;
            g   = euclid_gcd(num, den);
        end
        rden = den / g;
        rnum = num / g;
        mult = tgt / rden + 1;
        tmp  = rden * mult;
        res.frame_length = tmp[FL_W-1:0];
        tmp  = rnum * mult;
        res.time_scale = tmp[TS_W-1:0];
        return res;
    endfunction

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        err_cnt++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    task automatic check_norm(input t_norm_out got);
        t_norm_out want;
        if (norm_exp_q.size() == 0) begin
            err_cnt++;
            $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                     $time, got.bad_rate, got.frame_length, got.time_scale);
            return;
        end
        want = norm_exp_q.pop_front();
        if (got.bad_rate !== want.bad_rate)
            report_field("bad_rate", 64'(want.bad_rate), 64'(got.bad_rate));
        if (got.frame_length !== want.frame_length)
            report_field("frame_length", 64'(want.frame_length), 64'(got.frame_length));
        if (got.time_scale !== want.time_scale)
            report_field("time_scale", 64'(want.time_scale), 64'(got.time_scale));
    endtask

    // Result side: random stalls, counted either from the last transaction or
    // from the moment a result shows up, plus an optional long hold-off.
    int   rx_gap      = 0;
    logic rx_on_valid = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            norm_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (norm_if.valid && norm_if.ready) begin
                check_norm(norm_if.data);
                rx_gap      = idle_on ? $urandom_range(0, 10) : 0;
                rx_on_valid = 1'($urandom_range(0, 1));
            end
            if (rx_hold_len != 0) begin
                rx_gap      = rx_hold_len;
                rx_on_valid = 1'b0;
                rx_hold_len = 0;
            end
            if (rx_gap > 0) begin
                norm_if.ready <= 1'b0;
                if (!rx_on_valid || norm_if.valid)
                    rx_gap--;
            end else begin
                norm_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_rate(input logic [31:0] num, input logic [31:0] den);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            rate_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rate_if.valid <= 1'b1;
        rate_if.data  <= {num, den};
        do @(posedge i_clk); while (!(rate_if.valid && rate_if.ready));
        norm_exp_q.push_back(normalize_rate(num, den));
    endtask

    task automatic wait_idle();
        rate_if.valid <= 1'b0;
        while (norm_exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= {idx, val};
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == REG_MAX_DEN)
            max_den_q = val;
        else if (idx == REG_TARGET)
            target_q = val;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_rate();
        logic [31:0] n, d, k;
        int          cls;
        cls = $urandom_range(0, 99);
        if (cls < 20) begin
            n = $urandom_range(0, 255);
            d = $urandom_range(0, 255);
        end else if (cls < 35) begin
            case ($urandom_range(0, 7))
                0: n = 24000;
                1: n = 30000;
                2: n = 60000;
                3: n = 25;
                4: n = 30;
                5: n = 50;
                6: n = 48;
                default: n = 15000;
            endcase
            case ($urandom_range(0, 4))
                0: d = 1001;
                1: d = 1;
                2: d = 1000;
                3: d = 2002;
                default: d = 2;
            endcase
        end else if (cls < 50) begin
            n = $urandom_range(0, 65535);
            d = $urandom_range(1, 65535);
        end else if (cls < 62) begin
            // shared factor so the first reduction does real work
            k = $urandom_range(1, 4000);
            n = $urandom_range(1, 1000) * k;
            d = $urandom_range(1, 1000) * k;
        end else if (cls < 75) begin
            n = $urandom;
            d = $urandom_range(1, 600);
        end else if (cls < 80) begin
            n = $urandom_range(0, 300);
            d = $urandom;
        end else if (cls < 85) begin
            n = $urandom;
            d = 0;
        end else begin
            n = $urandom;
            d = $urandom;
        end
        return {n, d};
    endfunction

    task automatic test_reset_defaults();
        send_rate(30000, 1001);
        send_rate(25, 1);
        send_rate(24000, 1001);
        send_rate(60, 2);
        wait_idle();
    endtask

    task automatic test_special_rates();
        send_rate(0, 0);
        send_rate(32'hFFFF_FFFF, 0);
        send_rate(5, 0);
        send_rate(0, 7);
        send_rate(0, 32'hFFFF_FFFF);
        send_rate(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_rate(32'hFFFF_FFFF, 1);
        send_rate(1, 32'hFFFF_FFFF);
        send_rate(1, 1);
        // rescale remainder exactly at max/2, then above it
        send_rate(51, 101);
        send_rate(52, 101);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_MAX_DEN, 8'd0);
        write_reg(REG_TARGET, 8'd0);
        send_rate(7, 3);
        send_rate(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        wait_idle();
        write_reg(REG_MAX_DEN, 8'd255);
        write_reg(REG_TARGET, 8'd255);
        send_rate(30000, 1001);
        send_rate(1, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(REG_MAX_DEN, 8'd1);
        write_reg(REG_TARGET, 8'd128);
        send_rate(5, 2);
        wait_idle();
        // writes to unmapped indexes leave both registers alone
        write_reg(8'd2, 8'hA5);
        write_reg(8'hFF, 8'h5A);
        send_rate(30000, 1001);
        wait_idle();
    endtask

    task automatic test_output_stall();
        int i;
        idle_on = 1'b0;
        rx_hold_len = 4000;
        for (i = 0; i < 6; i++)
            send_rate($urandom_range(1, 5000), $urandom_range(1, 5000));
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_rates();
        int          ph, i;
        logic [63:0] r;
        for (ph = 0; ph < 11; ph++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: write_reg(REG_MAX_DEN, 8'd0);
                1: write_reg(REG_MAX_DEN, 8'd1);
                2: write_reg(REG_MAX_DEN, 8'd255);
                default: write_reg(REG_MAX_DEN, 8'($urandom_range(1, 255)));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(REG_TARGET, 8'd0);
                1: write_reg(REG_TARGET, 8'd255);
                default: write_reg(REG_TARGET, 8'($urandom_range(0, 255)));
            endcase
            idle_on = (ph % 4 != 3);
            for (i = 0; i < 125; i++) begin
                r = rand_rate();
                send_rate(r[63:32], r[31:0]);
            end
        end
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        rate_if.valid = 1'b0;
        rate_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_rates();
        test_register_extremes();
        test_output_stall();
        test_random_rates();

        repeat (2500) @(posedge i_clk);
        if (err_cnt == 0 && norm_exp_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
